/* sv/wpcf_pkg.sv */
// Shared types, constants and register map of the waveform pulse charge finder.
`timescale 1ns / 1ps
package wpcf_pkg;

  // Widths fixed by the register and result formats
  localparam int unsigned CFG_BITS    = 12;
  localparam int unsigned LIMIT_BITS  = 16;
  localparam int unsigned CHAN_BITS   = 13;
  localparam int unsigned WIRE_BITS   = 12;
  localparam int unsigned SUM_BITS    = 32;
  localparam int unsigned HITS_BITS   = 16;
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned ADDR_BITS   = 4;
  localparam int unsigned DATA_BITS   = 32;

  // Default parameter values
  localparam int unsigned DEF_SAMPLE_BITS = 12;
  localparam int unsigned DEF_TIME_BITS   = 24;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [CFG_BITS-1:0]   BASELINE_RST  = 12'd400;
  localparam logic [CFG_BITS-1:0]   THRESHOLD_RST = 12'd7;
  localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RST = 16'd100;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_BASELINE  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_LOW_LIMIT = 2'd2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PULSE = 2'd0,
    KIND_WIRE  = 2'd1,
    KIND_EVENT = 2'd2
  } wpcf_kind_e;

  // Register values seen by the front end
  typedef struct packed {
    logic [CFG_BITS-1:0]   baseline;
    logic [CFG_BITS-1:0]   threshold;
    logic [LIMIT_BITS-1:0] low_limit;
  } wpcf_cfg_t;

  // Up to three results caused by one sample, in delivery order
  typedef struct packed {
    logic                  pulse_v;
    logic [SUM_BITS-1:0]   pulse_charge;
    logic                  pulse_low;
    logic [HITS_BITS-1:0]  pulse_hits;
    logic                  wire_v;
    logic [SUM_BITS-1:0]   wire_charge;
    logic [WIRE_BITS-1:0]  wire_idx;
    logic                  evt_v;
    logic [SUM_BITS-1:0]   evt_charge;
    logic [HITS_BITS-1:0]  evt_hits;
  } wpcf_bundle_t;

  // Saturating add of two sums
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

endpackage

/* sv/wpcf_front.sv */
// Front end: takes samples, tracks pulse/wire/event state, builds result bundles.
`timescale 1ns / 1ps
module wpcf_front
  import wpcf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wpcf_cfg_t              cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_value_i,
  input  logic [TIME_BITS-1:0]   sample_time_i,
  input  logic [CHAN_BITS-1:0]   channel_i,
  input  logic [WIRE_BITS-1:0]   wire_index_i,
  input  logic                   is_collection_i,
  input  logic                   first_of_waveform_i,
  input  logic                   last_of_waveform_i,
  input  logic                   last_of_event_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output wpcf_bundle_t           bundle_o
);

  localparam int unsigned EXW = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;

  logic [TIME_BITS-1:0] lct_q, lct_d;
  logic [CHAN_BITS-1:0] prev_chan_q, prev_chan_d;
  logic                 have_prev_q, have_prev_d;
  logic                 in_pulse_q, in_pulse_d;
  logic [SUM_BITS-1:0]  pulse_sum_q, pulse_sum_d;
  logic [SUM_BITS-1:0]  wire_sum_q, wire_sum_d;
  logic [SUM_BITS-1:0]  evt_sum_q, evt_sum_d;
  logic [HITS_BITS-1:0] hits_q, hits_d;

  logic                 accept;
  logic [TIME_BITS-1:0] lct_f;
  logic                 in_pulse_f;
  logic [EXW-1:0]       excess;
  logic                 meets, later, count, close;
  logic [SUM_BITS-1:0]  q_charge;
  logic [SUM_BITS-1:0]  pulse_add, wire_add, evt_add;
  logic [HITS_BITS-1:0] hits_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Waveform start view of the state
  always_comb begin
    in_pulse_f = first_of_waveform_i ? 1'b0 : in_pulse_q;
    lct_f      = lct_q;
    if (first_of_waveform_i && have_prev_q && (channel_i != prev_chan_q)) begin
      lct_f = '0;
    end
  end

  // Threshold test and counting
  assign excess   = EXW'(sample_value_i) - EXW'(cfg_i.baseline);
  assign meets    = !excess[EXW-1] && (excess >= EXW'(cfg_i.threshold));
  assign later    = sample_time_i > lct_f;
  assign count    = is_collection_i && meets && later;
  assign close    = is_collection_i && !meets && in_pulse_f;
  assign q_charge = count ? SUM_BITS'(excess) : '0;

  assign pulse_add = sat_add(pulse_sum_q, q_charge);
  assign wire_add  = sat_add(wire_sum_q, q_charge);
  assign evt_add   = sat_add(evt_sum_q, q_charge);
  assign hits_new  = (close && (hits_q != {HITS_BITS{1'b1}})) ? hits_q + 1'b1 : hits_q;

  // Result bundle
  always_comb begin
    bundle_o.pulse_v      = close;
    bundle_o.pulse_charge = pulse_sum_q;
    bundle_o.pulse_low    = pulse_sum_q < SUM_BITS'(cfg_i.low_limit);
    bundle_o.pulse_hits   = hits_new;
    bundle_o.wire_v       = last_of_waveform_i && is_collection_i;
    bundle_o.wire_charge  = wire_add;
    bundle_o.wire_idx     = wire_index_i;
    bundle_o.evt_v        = last_of_event_i;
    bundle_o.evt_charge   = evt_add;
    bundle_o.evt_hits     = hits_new;
  end

  assign push_o = accept && (bundle_o.pulse_v || bundle_o.wire_v || bundle_o.evt_v);

  // Next state
  always_comb begin
    lct_d       = count ? sample_time_i : lct_f;
    prev_chan_d = first_of_waveform_i ? channel_i : prev_chan_q;
    have_prev_d = have_prev_q || first_of_waveform_i;
    pulse_sum_d = close ? '0 : pulse_add;
    wire_sum_d  = last_of_waveform_i ? '0 : wire_add;
    evt_sum_d   = evt_add;
    hits_d      = hits_new;
    if (count) begin
      in_pulse_d = 1'b1;
    end else if (is_collection_i && !meets) begin
      in_pulse_d = 1'b0;
    end else begin
      in_pulse_d = in_pulse_f;
    end
    if (last_of_waveform_i) begin
      in_pulse_d = 1'b0;
    end
    // Event end returns everything to zero
    if (last_of_event_i) begin
      lct_d       = '0;
      prev_chan_d = '0;
      have_prev_d = 1'b0;
      in_pulse_d  = 1'b0;
      pulse_sum_d = '0;
      wire_sum_d  = '0;
      evt_sum_d   = '0;
      hits_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lct_q       <= '0;
      prev_chan_q <= '0;
      have_prev_q <= 1'b0;
      in_pulse_q  <= 1'b0;
      pulse_sum_q <= '0;
      wire_sum_q  <= '0;
      evt_sum_q   <= '0;
      hits_q      <= '0;
    end else if (accept) begin
      lct_q       <= lct_d;
      prev_chan_q <= prev_chan_d;
      have_prev_q <= have_prev_d;
      in_pulse_q  <= in_pulse_d;
      pulse_sum_q <= pulse_sum_d;
      wire_sum_q  <= wire_sum_d;
      evt_sum_q   <= evt_sum_d;
      hits_q      <= hits_d;
    end
  end

endmodule

/* sv/wpcf_queue.sv */
// Short bundle queue between the front end and the result serialiser.
`timescale 1ns / 1ps
module wpcf_queue
  import wpcf_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  wpcf_bundle_t push_data_i,
  input  logic         pop_i,
  output wpcf_bundle_t head_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wpcf_bundle_t    slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue fill count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i == pop_i) |=> $stable(cnt_q)) else $error("fill count moved without net change");

endmodule

/* sv/wpcf_back.sv */
// Back end: unpacks bundles into single result words behind an output register.
`timescale 1ns / 1ps
module wpcf_back
  import wpcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wpcf_bundle_t          head_i,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KIND_BITS-1:0]  result_kind_o,
  output logic [SUM_BITS-1:0]   charge_o,
  output logic [WIRE_BITS-1:0]  wire_out_o,
  output logic                  low_energy_o,
  output logic [HITS_BITS-1:0]  hit_count_o,
  output logic                  last_result_o
);

  wpcf_bundle_t         wk_q, wk_d;
  logic [2:0]           pend_q, pend_d;
  logic                 ovalid_q;
  logic [KIND_BITS-1:0] kind_q;
  logic [SUM_BITS-1:0]  charge_q;
  logic [WIRE_BITS-1:0] wire_q;
  logic                 low_q;
  logic [HITS_BITS-1:0] hits_q;
  logic                 last_q;

  logic                 emit;
  logic [2:0]           sel;
  logic [2:0]           pend_after;
  wpcf_kind_e           sel_kind;
  logic [SUM_BITS-1:0]  sel_charge;
  logic [WIRE_BITS-1:0] sel_wire;
  logic                 sel_low;
  logic [HITS_BITS-1:0] sel_hits;

  // Pick the oldest pending result of the working bundle
  always_comb begin
    sel        = 3'b000;
    sel_kind   = KIND_EVENT;
    sel_charge = wk_q.evt_charge;
    sel_wire   = '0;
    sel_low    = 1'b0;
    sel_hits   = wk_q.evt_hits;
    if (pend_q[0]) begin
      sel        = 3'b001;
      sel_kind   = KIND_PULSE;
      sel_charge = wk_q.pulse_charge;
      sel_low    = wk_q.pulse_low;
      sel_hits   = wk_q.pulse_hits;
    end else if (pend_q[1]) begin
      sel        = 3'b010;
      sel_kind   = KIND_WIRE;
      sel_charge = wk_q.wire_charge;
      sel_wire   = wk_q.wire_idx;
      sel_hits   = '0;
    end else if (pend_q[2]) begin
      sel        = 3'b100;
    end
  end

  assign emit       = (pend_q != 3'b000) && (!ovalid_q || out_ready_i);
  assign pend_after = emit ? (pend_q & ~sel) : pend_q;
  assign pop_o      = (pend_after == 3'b000) && !q_empty_i;

  // Refill the working bundle as the last result leaves
  always_comb begin
    wk_d   = wk_q;
    pend_d = pend_after;
    if (pop_o) begin
      wk_d   = head_i;
      pend_d = {head_i.evt_v, head_i.wire_v, head_i.pulse_v};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 3'b000;
      ovalid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wk_q <= wk_d;
    end
    if (emit) begin
      kind_q   <= sel_kind;
      charge_q <= sel_charge;
      wire_q   <= sel_wire;
      low_q    <= sel_low;
      hits_q   <= sel_hits;
      last_q   <= (pend_q & ~sel) == 3'b000;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign result_kind_o = kind_q;
  assign charge_o      = charge_q;
  assign wire_out_o    = wire_q;
  assign low_energy_o  = low_q;
  assign hit_count_o   = hits_q;
  assign last_result_o = last_q;

endmodule

/* sv/waveform_pulse_charge_finder.sv */
// Top level of the waveform pulse charge finder: registers, front end, queue, back end.
//
// Samples enter on the input channel (in_valid_i/in_ready_o), one word per
// sample with its time tick, channel, wire and boundary flags. Results leave
// on the output channel (out_valid_o/out_ready_i), one word per result, in
// the order pulse closed, wire sum, event summary; last_result_o marks the
// final word caused by a sample. A sample may cause zero to three words.
// Throughput: one sample per cycle while the queue is not full; results leave
// at one word per cycle while the receiver is ready. The front end updates all
// sums in the cycle a sample is accepted; a four-entry bundle queue (QUEUE_DEPTH)
// decouples it from the serialiser. The first result of a sample passes the queue
// slot, the working bundle and the output register before it is valid. When the
// receiver stalls the output word is held, the queue fills and in_ready_o falls
// once it is full; bursts of multi-result samples that outrun the output likewise
// fill the queue. Reset clears all pulse, wire and event state and the queue, and
// loads the registers with baseline 400, threshold 7 and low-energy limit 100.
// Registers sit at byte addresses 0, 4 and 8 of the APB-style port; the user must see
// that they are written only while the block is idle; it does not enforce this.
`timescale 1ns / 1ps
module waveform_pulse_charge_finder
  import wpcf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready,
  // sample channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_value_i,
  input  logic [TIME_BITS-1:0]   sample_time_i,
  input  logic [CHAN_BITS-1:0]   channel_i,
  input  logic [WIRE_BITS-1:0]   wire_index_i,
  input  logic                   is_collection_i,
  input  logic                   first_of_waveform_i,
  input  logic                   last_of_waveform_i,
  input  logic                   last_of_event_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KIND_BITS-1:0]   result_kind_o,
  output logic [SUM_BITS-1:0]    charge_o,
  output logic [WIRE_BITS-1:0]   wire_out_o,
  output logic                   low_energy_o,
  output logic [HITS_BITS-1:0]   hit_count_o,
  output logic                   last_result_o
);

  wpcf_cfg_t    cfg_q;
  logic         cfg_wr;
  logic [1:0]   reg_idx;
  logic         push, pop, q_full, q_empty;
  wpcf_bundle_t push_bundle, head_bundle;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline  <= BASELINE_RST;
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.low_limit <= LOW_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BASELINE:  cfg_q.baseline  <= pwdata[CFG_BITS-1:0];
        REG_THRESHOLD: cfg_q.threshold <= pwdata[CFG_BITS-1:0];
        REG_LOW_LIMIT: cfg_q.low_limit <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_BASELINE:  prdata = DATA_BITS'(cfg_q.baseline);
      REG_THRESHOLD: prdata = DATA_BITS'(cfg_q.threshold);
      REG_LOW_LIMIT: prdata = DATA_BITS'(cfg_q.low_limit);
      default:       prdata = '0;
    endcase
  end

  wpcf_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_value_i      (sample_value_i),
    .sample_time_i       (sample_time_i),
    .channel_i           (channel_i),
    .wire_index_i        (wire_index_i),
    .is_collection_i     (is_collection_i),
    .first_of_waveform_i (first_of_waveform_i),
    .last_of_waveform_i  (last_of_waveform_i),
    .last_of_event_i     (last_of_event_i),
    .q_full_i            (q_full),
    .push_o              (push),
    .bundle_o            (push_bundle)
  );

  wpcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  wpcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_bundle),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .charge_o      (charge_o),
    .wire_out_o    (wire_out_o),
    .low_energy_o  (low_energy_o),
    .hit_count_o   (hit_count_o),
    .last_result_o (last_result_o)
  );

endmodule
